### hdl/ipyf_pkg.sv
package ipyf_pkg;

	localparam int IDX_W = 5;
	localparam int CW = 26;
	localparam int NW = 37;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_POFF = 2'd1;
	localparam logic [1:0] REG_YOFF = 2'd2;
	localparam logic [1:0] REG_DB = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CORD,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_PRED,
		ST_FMUL,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		JOB_PR,
		JOB_YR,
		JOB_PI,
		JOB_YI
	} job_t;

	typedef struct packed {
		logic load;
		logic cord_step;
		logic [IDX_W-1:0] cord_idx;
		logic div_go;
		logic div_store;
		job_t job;
		logic mul;
		logic pred;
		logic fmul;
		logic write;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
	} stat_t;

	function automatic logic [CW-1:0] atan_q16(input logic [IDX_W-1:0] i);
		logic [CW-1:0] r;
		case (i)
			5'd0: r = 26'd2949120;
			5'd1: r = 26'd1740967;
			5'd2: r = 26'd919879;
			5'd3: r = 26'd466945;
			5'd4: r = 26'd234379;
			5'd5: r = 26'd117304;
			5'd6: r = 26'd58666;
			5'd7: r = 26'd29335;
			5'd8: r = 26'd14668;
			5'd9: r = 26'd7334;
			5'd10: r = 26'd3667;
			5'd11: r = 26'd1833;
			5'd12: r = 26'd917;
			5'd13: r = 26'd458;
			5'd14: r = 26'd229;
			5'd15: r = 26'd115;
			5'd16: r = 26'd57;
			5'd17: r = 26'd29;
			5'd18: r = 26'd14;
			5'd19: r = 26'd7;
			5'd20: r = 26'd4;
			5'd21: r = 26'd2;
			5'd22: r = 26'd1;
			default: r = 26'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/ipyf_div.sv
module ipyf_div #(
	parameter int NUM_W = 37
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             mega,
	input  logic [NUM_W-1:0] num,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	// divide by 115 as n * ceil(2^35 / 115) >> 35, n below 2^28
	// divide by 1000000 as (n >> 6) * ceil(2^45 / 15625) >> 45, n below 2^37
	localparam logic [31:0] RECIP_115 = 32'd298780334;
	localparam logic [31:0] RECIP_15625 = 32'd2251799814;
	localparam int SHIFT_115 = 35;
	localparam int SHIFT_MEGA = 45;

	logic [31:0] op_q;
	logic mega_q;
	logic [63:0] prod_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= mega ? 32'(num >> 6) : 32'(num);
			mega_q <= mega;
		end
		if (busy_q)
			prod_q <= 64'(op_q) * 64'(mega_q ? RECIP_15625 : RECIP_115);
	end

	assign quo = mega_q ? NUM_W'(prod_q >> SHIFT_MEGA) : NUM_W'(prod_q >> SHIFT_115);
	assign done = done_q;
endmodule

### hdl/ipyf_ctrl.sv
module ipyf_ctrl #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ipyf_pkg::stat_t stat,
	output ipyf_pkg::cmd_t  cmd
);
	import ipyf_pkg::*;

	state_t state_q, state_d;
	job_t job_q, job_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_PR;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			job_q <= job_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		job_d = job_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.job = job_q;
		cmd.cord_idx = cnt_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					state_d = ST_CORD;
				end
			end
			ST_CORD: begin
				cmd.cord_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == IDX_W'(CORDIC_ITERATIONS - 1)) begin
					job_d = JOB_PR;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					cmd.div_store = 1'b1;
					case (job_q)
						JOB_PR: begin
							job_d = JOB_YR;
							state_d = ST_DIV_GO;
						end
						JOB_YR: state_d = ST_MUL;
						JOB_PI: begin
							job_d = JOB_YI;
							state_d = ST_DIV_GO;
						end
						default: state_d = ST_PRED;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				job_d = JOB_PI;
				state_d = ST_DIV_GO;
			end
			ST_PRED: begin
				cmd.pred = 1'b1;
				state_d = ST_FMUL;
			end
			ST_FMUL: begin
				cmd.fmul = 1'b1;
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!stat.out_busy) begin
					cmd.write = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### hdl/ipyf_datapath.sv
module ipyf_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ipyf_pkg::cmd_t     cmd,
	output ipyf_pkg::stat_t    stat,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_pitch_raw,
	input  logic signed [15:0] gyro_yaw_raw,
	input  logic [15:0]        step_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pitch_angle,
	output logic signed [16:0] accel_pitch,
	output logic signed [20:0] pitch_rate,
	output logic signed [20:0] yaw_rate,
	output logic signed [31:0] yaw_angle
);
	import ipyf_pkg::*;

	function automatic logic signed [20:0] sat_rate(input logic [NW-1:0] q, input logic neg);
		logic signed [20:0] r;
		if (neg)
			r = (q > NW'(1048576)) ? -21'sd1048576 : 21'(-$signed({1'b0, q}));
		else
			r = (q > NW'(1048575)) ? 21'sd1048575 : 21'(q);
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
		logic signed [31:0] r;
		if (s[32] != s[31])
			r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		else
			r = s[31:0];
		return r;
	endfunction

	logic [15:0] alpha_q;
	logic signed [19:0] poff_q, yoff_q;
	logic [15:0] db_q;

	logic signed [CW-1:0] x_q, v_q, ang_q;
	logic zero_q;
	logic [15:0] dt_q;
	logic signed [20:0] dp_q, dy_q;
	logic signed [20:0] prate_q, yrate_q;
	logic signed [37:0] prod_p_q, prod_y_q;
	logic signed [17:0] inc_p_q, inc_y_q;
	logic signed [16:0] accp_q;
	logic signed [32:0] pred_q;
	logic signed [31:0] yaw_new_q;
	logic signed [50:0] prod_f_q;
	logic signed [31:0] pitch_acc_q, yaw_acc_q;
	logic out_valid_q;

	logic signed [CW-1:0] z256, y256;
	logic [20:0] dmag;
	logic [NW-1:0] div_num, quo;
	logic div_mega;
	logic div_done;
	logic neg;
	logic signed [20:0] yr_sat;
	logic [20:0] yr_mag;
	logic [CW-1:0] ang_mag;
	logic [17:0] ang_rnd;
	logic signed [51:0] fsum;
	logic [51:0] fmag;
	logic [35:0] fq;
	logic signed [32:0] fsig;

	assign z256 = CW'($signed({accel_z, 8'b0}));
	assign y256 = CW'($signed({accel_y, 8'b0}));

	always_comb begin
		dmag = '0;
		div_num = '0;
		div_mega = 1'b0;
		neg = 1'b0;
		case (cmd.job)
			JOB_PR: begin
				neg = dp_q[20];
				dmag = neg ? 21'(-dp_q) : 21'(dp_q);
				div_num = NW'({dmag, 7'b0}) + NW'(57);
			end
			JOB_YR: begin
				neg = dy_q[20];
				dmag = neg ? 21'(-dy_q) : 21'(dy_q);
				div_num = NW'({dmag, 7'b0}) + NW'(57);
			end
			JOB_PI: begin
				neg = prod_p_q[37];
				div_num = (neg ? NW'(-prod_p_q) : NW'(prod_p_q)) + NW'(500000);
				div_mega = 1'b1;
			end
			default: begin
				neg = prod_y_q[37];
				div_num = (neg ? NW'(-prod_y_q) : NW'(prod_y_q)) + NW'(500000);
				div_mega = 1'b1;
			end
		endcase
	end

	ipyf_div #(.NUM_W(NW)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_go),
		.mega  (div_mega),
		.num   (div_num),
		.quo   (quo),
		.done  (div_done)
	);

	assign yr_sat = sat_rate(quo, neg);
	assign yr_mag = yr_sat[20] ? 21'(-yr_sat) : 21'(yr_sat);
	assign ang_mag = ang_q[CW-1] ? CW'(-ang_q) : CW'(ang_q);
	assign ang_rnd = 18'((ang_mag + CW'(128)) >> 8);
	assign fsum = (52'(accp_q) <<< 16) + 52'(prod_f_q);
	assign fmag = fsum[51] ? 52'(-fsum) : 52'(fsum);
	assign fq = 36'((fmag + 52'(32768)) >> 16);

	always_comb begin
		if (fsum[51])
			fsig = (fq > 36'h0_8000_0000) ? -33'sd2147483648 : 33'(-$signed({1'b0, fq}));
		else
			fsig = (fq > 36'h0_7fff_ffff) ? 33'sd2147483647 : 33'(fq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd64880;
			poff_q <= '0;
			yoff_q <= '0;
			db_q <= 16'd128;
			pitch_acc_q <= '0;
			yaw_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_ALPHA: alpha_q <= cfg_data[15:0];
					REG_POFF: poff_q <= cfg_data;
					REG_YOFF: yoff_q <= cfg_data;
					REG_DB: db_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.write) begin
				pitch_acc_q <= fsig[31:0];
				yaw_acc_q <= yaw_new_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q <= (accel_y == 16'sd0) && (accel_z == 16'sd0);
			dt_q <= step_us;
			dp_q <= 21'($signed({gyro_pitch_raw, 4'b0})) - 21'(poff_q);
			dy_q <= 21'($signed({gyro_yaw_raw, 4'b0})) - 21'(yoff_q);
			if (accel_z < 16'sd0) begin
				x_q <= -z256;
				v_q <= -y256;
				ang_q <= (accel_y >= 16'sd0) ? CW'(11796480) : -CW'(11796480);
			end else begin
				x_q <= z256;
				v_q <= y256;
				ang_q <= '0;
			end
		end
		if (cmd.cord_step) begin
			if (!v_q[CW-1]) begin
				x_q <= x_q + (v_q >>> cmd.cord_idx);
				v_q <= v_q - (x_q >>> cmd.cord_idx);
				ang_q <= ang_q + $signed(atan_q16(cmd.cord_idx));
			end else begin
				x_q <= x_q - (v_q >>> cmd.cord_idx);
				v_q <= v_q + (x_q >>> cmd.cord_idx);
				ang_q <= ang_q - $signed(atan_q16(cmd.cord_idx));
			end
		end
		if (cmd.div_store) begin
			case (cmd.job)
				JOB_PR: prate_q <= yr_sat;
				JOB_YR: yrate_q <= (yr_mag < {5'b0, db_q}) ? 21'sd0 : yr_sat;
				JOB_PI: inc_p_q <= neg ? 18'(-$signed({1'b0, quo})) : 18'(quo);
				default: inc_y_q <= neg ? 18'(-$signed({1'b0, quo})) : 18'(quo);
			endcase
		end
		if (cmd.mul) begin
			prod_p_q <= 38'(prate_q) * $signed({22'b0, dt_q});
			prod_y_q <= 38'(yrate_q) * $signed({22'b0, dt_q});
			if (zero_q)
				accp_q <= '0;
			else if (ang_rnd > 18'd46080)
				accp_q <= ang_q[CW-1] ? -17'sd46080 : 17'sd46080;
			else
				accp_q <= ang_q[CW-1] ? 17'(-$signed({1'b0, ang_rnd})) : 17'(ang_rnd);
		end
		if (cmd.pred) begin
			pred_q <= 33'(pitch_acc_q) + 33'(inc_p_q);
			yaw_new_q <= sat32(33'(yaw_acc_q) + 33'(inc_y_q));
		end
		if (cmd.fmul)
			prod_f_q <= 51'($signed({1'b0, alpha_q})) * (51'(pred_q) - 51'(accp_q));
		if (cmd.write) begin
			pitch_angle <= fsig[31:0];
			accel_pitch <= accp_q;
			pitch_rate <= prate_q;
			yaw_rate <= yrate_q;
			yaw_angle <= yaw_new_q;
		end
	end

	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
endmodule

### hdl/imu_pitch_yaw_fusion.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    accel_y accel_z gyro_pitch_raw gyro_yaw_raw step_us
// out      output     out_valid / out_ready  pitch_angle accel_pitch pitch_rate yaw_rate yaw_angle
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
// After accept, the CORDIC loop runs one iteration a cycle, then one shared reciprocal multiplier
// serves four divisions in turn, each started only once the previous one is done.
// A new word is accepted once the previous one is in the output register.
// arst_n clears the control state and the pitch and yaw accumulators, and sets the registers to defaults.
// A stalled result holds in the output register; the last step waits for it to drain.
module imu_pitch_yaw_fusion #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_pitch_raw,
	input  logic signed [15:0] gyro_yaw_raw,
	input  logic [15:0]        step_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pitch_angle,
	output logic signed [16:0] accel_pitch,
	output logic signed [20:0] pitch_rate,
	output logic signed [20:0] yaw_rate,
	output logic signed [31:0] yaw_angle,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data
);
	import ipyf_pkg::*;

	cmd_t cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	ipyf_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ipyf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.gyro_pitch_raw(gyro_pitch_raw),
		.gyro_yaw_raw  (gyro_yaw_raw),
		.step_us       (step_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pitch_angle   (pitch_angle),
		.accel_pitch   (accel_pitch),
		.pitch_rate    (pitch_rate),
		.yaw_rate      (yaw_rate),
		.yaw_angle     (yaw_angle)
	);
endmodule

### hdl/ipyf_checker.sv
module ipyf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] pitch_angle,
	input logic signed [16:0] accel_pitch,
	input logic signed [31:0] yaw_angle
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(yaw_angle))
		else $error("result word changed while stalled");

	a_accel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accel_pitch <= 17'sd46080) && (accel_pitch >= -17'sd46080))
		else $error("accel pitch out of range");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
		else $error("result appeared one cycle after accept");
endmodule

bind imu_pitch_yaw_fusion ipyf_checker u_ipyf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pitch_angle(pitch_angle),
	.accel_pitch(accel_pitch),
	.yaw_angle  (yaw_angle)
);

### tb/ipyf_checker.sv
module ipyf_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_pitch_raw,
	input  logic signed [15:0] gyro_yaw_raw,
	input  logic [15:0]        step_us,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pitch_angle,
	input  logic signed [16:0] accel_pitch,
	input  logic signed [20:0] pitch_rate,
	input  logic signed [20:0] yaw_rate,
	input  logic signed [31:0] yaw_angle,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	output int                 fail_count,
	output int                 outstanding
);
	import ipyf_pkg::*;

	localparam int CORDIC_STEPS = 16;
	localparam longint RATE_HI = 1048575;
	localparam longint RATE_LO = -1048576;
	localparam longint HALF_TURN = 46080;
	localparam longint ATAN_Q16 [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic signed [31:0] pitch;
		logic signed [16:0] acc_pitch;
		logic signed [20:0] prate;
		logic signed [20:0] yrate;
		logic signed [31:0] yaw;
	} sample_result_t;

	sample_result_t fused_q[$];
	longint alpha_w, deadband;
	logic signed [19:0] pitch_bias, yaw_bias;
	logic signed [31:0] pitch_est, yaw_est;

	function automatic longint div_near(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint dps_q8(longint raw, longint bias);
		return clip(div_near((raw * 16 - bias) * 128, 115), RATE_LO, RATE_HI);
	endfunction

	function automatic longint tilt_q8(longint y, longint z);
		longint x, v, ang, dx, dy;
		if (y == 0 && z == 0)
			return 0;
		x = z * 256;
		v = y * 256;
		ang = 0;
		if (z < 0) begin
			x = -x;
			v = -v;
			ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = v >>> i;
			dy = x >>> i;
			if (v >= 0) begin
				x += dx;
				v -= dy;
				ang += ATAN_Q16[i];
			end else begin
				x -= dx;
				v += dy;
				ang -= ATAN_Q16[i];
			end
		end
		return clip(div_near(ang, 256), -HALF_TURN, HALF_TURN);
	endfunction

	function automatic sample_result_t fuse_sample(longint ay, longint az, longint gp,
			longint gy, longint dt);
		sample_result_t r;
		longint ap, pr, yr, pred, yw;
		ap = tilt_q8(ay, az);
		pr = dps_q8(gp, longint'(pitch_bias));
		yr = dps_q8(gy, longint'(yaw_bias));
		pred = longint'(pitch_est) + div_near(pr * dt, 1000000);
		pitch_est = 32'(clip(div_near(alpha_w * pred + (65536 - alpha_w) * ap, 65536),
			-64'sd2147483648, 64'sd2147483647));
		if (((yr < 0) ? -yr : yr) < deadband)
			yr = 0;
		yw = longint'(yaw_est) + div_near(yr * dt, 1000000);
		yaw_est = 32'(clip(yw, -64'sd2147483648, 64'sd2147483647));
		r.pitch = pitch_est;
		r.acc_pitch = 17'(ap);
		r.prate = 21'(pr);
		r.yrate = 21'(yr);
		r.yaw = yaw_est;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_result_t want;
		if (!arst_n) begin
			alpha_w = 64880;
			pitch_bias = '0;
			yaw_bias = '0;
			deadband = 128;
			pitch_est = '0;
			yaw_est = '0;
			fused_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ALPHA: alpha_w = longint'(cfg_data[15:0]);
					REG_POFF: pitch_bias = cfg_data;
					REG_YOFF: yaw_bias = cfg_data;
					REG_DB: deadband = longint'(cfg_data[15:0]);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (fused_q.size() == 0) begin
					$error("result word with no sample waiting");
					fail_count++;
				end else begin
					want = fused_q.pop_front();
					if (pitch_angle !== want.pitch) begin
						$error("pitch_angle expected %0d got %0d", want.pitch, pitch_angle);
						fail_count++;
					end
					if (accel_pitch !== want.acc_pitch) begin
						$error("accel_pitch expected %0d got %0d", want.acc_pitch,
							accel_pitch);
						fail_count++;
					end
					if (pitch_rate !== want.prate) begin
						$error("pitch_rate expected %0d got %0d", want.prate, pitch_rate);
						fail_count++;
					end
					if (yaw_rate !== want.yrate) begin
						$error("yaw_rate expected %0d got %0d", want.yrate, yaw_rate);
						fail_count++;
					end
					if (yaw_angle !== want.yaw) begin
						$error("yaw_angle expected %0d got %0d", want.yaw, yaw_angle);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				fused_q.push_back(fuse_sample(longint'(accel_y), longint'(accel_z),
					longint'(gyro_pitch_raw), longint'(gyro_yaw_raw), longint'(step_us)));
			outstanding = fused_q.size();
		end
	end

endmodule

### tb/imu_pitch_yaw_fusion_test.sv
module imu_pitch_yaw_fusion_test;
	import ipyf_pkg::*;

	localparam int CYCLE_LIMIT = 1200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] accel_y = '0, accel_z = '0, gyro_pitch_raw = '0, gyro_yaw_raw = '0;
	logic [15:0] step_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pitch_angle, yaw_angle;
	logic signed [16:0] accel_pitch;
	logic signed [20:0] pitch_rate, yaw_rate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_ALPHA;
	logic [19:0] cfg_data = '0;
	int fail_count, outstanding;
	int send_idle_pct = 11, recv_idle_pct = 47;
	int hold_cycles = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	imu_pitch_yaw_fusion dut (.*);

	ipyf_scoreboard checker_i (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (hold_req && !hold_done) begin
			out_ready <= 1'b0;
			hold_cycles <= 2000;
			hold_done <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_sample(input logic [15:0] ay, az, gp, gy, dt);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		accel_y = ay;
		accel_z = az;
		gyro_pitch_raw = gp;
		gyro_yaw_raw = gy;
		step_us = dt;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_sample();
		logic [15:0] ay, az, gp, gy, dt;
		ay = 16'($urandom);
		az = 16'($urandom);
		gp = 16'($urandom);
		gy = 16'($urandom);
		dt = 16'($urandom);
		case ($urandom_range(5))
			0: gy = 16'($urandom_range(0, 60) - 30);
			1: begin
				ay = 16'($urandom_range(0, 8) - 4);
				az = 16'($urandom_range(0, 8) - 4);
			end
			2: dt = 16'($urandom_range(500, 1500));
			3: begin
				gp = 16'($urandom_range(0, 2000) - 1000);
				dt = 16'($urandom_range(0, 20000));
			end
			default: ;
		endcase
		send_sample(ay, az, gp, gy, dt);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1000);
		send_sample(16'sd0, -16'sd5, 16'sd100, 16'sd5, 16'd1000);
		send_sample(16'sd0, 16'sd5, -16'sd100, -16'sd5, 16'd0);
		send_sample(16'sd5, 16'sd0, 16'sd32767, 16'sd32767, 16'hffff);
		send_sample(-16'sd5, 16'sd0, -16'sd32768, -16'sd32768, 16'hffff);
		send_sample(16'sd32767, -16'sd32768, 16'sd7, 16'sd8, 16'd5000);
		send_sample(-16'sd32768, -16'sd32768, -16'sd7, -16'sd8, 16'd5000);
		send_sample(-16'sd1, -16'sd32768, 16'sd32767, 16'sd32767, 16'hffff);
		send_sample(-16'sd32768, 16'sd32767, 16'sd0, 16'sd0, 16'd1);
		send_sample(16'sd1, -16'sd32768, 16'sd0, 16'sd0, 16'd1);
		write_reg(REG_ALPHA, 20'h00000);
		write_reg(REG_POFF, 20'h7ffff);
		write_reg(REG_YOFF, 20'h80000);
		write_reg(REG_DB, 20'h00000);
		send_sample(16'sd100, 16'sd200, -16'sd32768, 16'sd32767, 16'hffff);
		send_sample(-16'sd100, -16'sd200, 16'sd32767, -16'sd32768, 16'hffff);
		send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0);
		write_reg(REG_ALPHA, 20'hfffff);
		write_reg(REG_POFF, 20'h80000);
		write_reg(REG_YOFF, 20'h7ffff);
		write_reg(REG_DB, 20'h0ffff);
		send_sample(16'sd300, 16'sd400, 16'sd32767, -16'sd32768, 16'hffff);
		send_sample(16'sd300, 16'sd400, -16'sd32768, 16'sd32767, 16'hffff);
		send_sample(16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'd100);

		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_ALPHA, (phase == 5) ? 20'hffff : 20'($urandom));
			write_reg(REG_POFF, 20'($urandom_range(0, 4000) - 2000));
			write_reg(REG_YOFF,
				(phase == 2) ? 20'hfffff : 20'($urandom_range(0, 4000) - 2000));
			write_reg(REG_DB,
				($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 400)));
			send_idle_pct = (phase < 2) ? 11 : (phase < 4) ? 47 : 0;
			recv_idle_pct = (phase < 2) ? 47 : (phase < 4) ? 11 : 0;
			if (phase == 1)
				hold_req = 1'b1;
			for (int n = 0; n < 230; n++)
				random_sample();
		end
		in_valid = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
